/* hw/rtl/btlpm_pkg.sv */
// Shared types and constants for the binary trie longest prefix match block.
// Used by the controller, the datapath and the top level; depends on nothing.
`default_nettype none

package btlpm_pkg;

  localparam int ADDR_W      = 32;
  localparam int PLEN_W      = 6;
  localparam int RID_W       = 16;
  localparam int IN_TDATA_W  = 56;
  localparam int OUT_TDATA_W = 24;

  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_LOOKUP = 1'b1;

  localparam logic STAT_DONE = 1'b0;
  localparam logic STAT_FULL = 1'b1;

  typedef struct packed {
    logic load;
    logic step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic finish;
  } stat_t;

endpackage

`default_nettype wire

/* hw/rtl/btlpm_datapath.sv */
// Datapath of the trie block: node memories, root node registers, walk registers.
// Follows commands from btlpm_ctrl; depends on btlpm_pkg.
`default_nettype none

module btlpm_datapath #(
  parameter int NODE_COUNT   = 4096,
  parameter int ADDRESS_BITS = 32
) (
  input  wire                               clk,
  input  wire                               rst,
  input  btlpm_pkg::cmd_t                   cmd,
  output btlpm_pkg::stat_t                  stat,
  input  wire                               in_action,
  input  wire  [btlpm_pkg::ADDR_W-1:0]      in_address,
  input  wire  [btlpm_pkg::PLEN_W-1:0]      in_plen,
  input  wire  [btlpm_pkg::RID_W-1:0]       in_rid,
  output logic                              out_found,
  output logic [btlpm_pkg::RID_W-1:0]       out_route,
  output logic                              out_status
);
  import btlpm_pkg::*;

  localparam int IW = $clog2(NODE_COUNT);
  localparam int FW = $clog2(NODE_COUNT + 1);
  localparam int LW = $clog2(ADDRESS_BITS + 1);
  localparam int RW = RID_W + 1;
  localparam logic [FW-1:0]     POOL_END = FW'(NODE_COUNT);
  localparam logic [LW-1:0]     LVL_END  = LW'(ADDRESS_BITS);
  localparam logic [PLEN_W-1:0] PLEN_MAX = PLEN_W'(ADDRESS_BITS);

  logic                    action;
  logic [ADDRESS_BITS-1:0] addr_sh;
  logic [LW-1:0]           plen;
  logic [RID_W-1:0]        rid;
  logic [IW-1:0]           cur;
  logic [LW-1:0]           lvl;
  logic                    fresh;
  logic [RW-1:0]           best;
  logic [FW-1:0]           next_free;
  logic [IW-1:0]           root_zero;
  logic [IW-1:0]           root_one;
  logic [RW-1:0]           root_route;

  logic [IW-1:0] zero_mem  [NODE_COUNT];
  logic [IW-1:0] one_mem   [NODE_COUNT];
  logic [RW-1:0] route_mem [NODE_COUNT];
  logic [IW-1:0] zero_q;
  logic [IW-1:0] one_q;
  logic [RW-1:0] route_q;

  logic          at_root;
  logic [IW-1:0] v_zero;
  logic [IW-1:0] v_one;
  logic [RW-1:0] v_route;
  logic          addr_bit;
  logic [IW-1:0] child;
  logic          pool_full;
  logic [IW-1:0] spare_node;
  logic [RW-1:0] best_n;
  logic [IW-1:0] rd_addr;

  logic             finish;
  logic             advance;
  logic             alloc;
  logic             res_status;
  logic             res_found;
  logic [RID_W-1:0] res_route;
  logic             wz_en;
  logic             wo_en;
  logic             wr_en;
  logic [IW-1:0]    wz_data;
  logic [IW-1:0]    wo_data;
  logic [RW-1:0]    wr_data;

  assign at_root    = (cur == '0);
  assign v_zero     = at_root ? root_zero : zero_q;
  assign v_one      = at_root ? root_one : one_q;
  assign v_route    = at_root ? root_route : route_q;
  assign addr_bit   = addr_sh[ADDRESS_BITS-1];
  assign child      = addr_bit ? v_one : v_zero;
  assign pool_full  = (next_free >= POOL_END);
  assign spare_node = next_free[IW-1:0];
  assign best_n     = v_route[RW-1] ? v_route : best;
  assign rd_addr    = (cmd.step && advance) ? child : cur;
  assign stat.finish = finish;

  always_comb begin
    finish     = 1'b0;
    advance    = 1'b0;
    alloc      = 1'b0;
    res_status = STAT_DONE;
    res_found  = 1'b0;
    res_route  = '0;
    wz_en      = 1'b0;
    wo_en      = 1'b0;
    wr_en      = 1'b0;
    wz_data    = '0;
    wo_data    = '0;
    wr_data    = '0;
    if (action == ACT_LOOKUP) begin
      if (lvl == LVL_END || child == '0) begin
        finish    = 1'b1;
        res_found = best_n[RW-1];
        res_route = best_n[RID_W-1:0];
      end else begin
        advance = 1'b1;
      end
    end else if (lvl == plen) begin
      finish  = 1'b1;
      wr_en   = 1'b1;
      wr_data = {1'b1, rid};
      wz_en   = fresh;
      wo_en   = fresh;
    end else if (fresh) begin
      wz_en = 1'b1;
      wo_en = 1'b1;
      wr_en = 1'b1;
      if (pool_full) begin
        finish     = 1'b1;
        res_status = STAT_FULL;
      end else begin
        alloc   = 1'b1;
        wz_data = addr_bit ? '0 : spare_node;
        wo_data = addr_bit ? spare_node : '0;
      end
    end else if (child != '0) begin
      advance = 1'b1;
    end else if (pool_full) begin
      finish     = 1'b1;
      res_status = STAT_FULL;
    end else begin
      alloc   = 1'b1;
      wz_en   = !addr_bit;
      wo_en   = addr_bit;
      wz_data = spare_node;
      wo_data = spare_node;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step && !at_root) begin
      if (wz_en) begin
        zero_mem[cur] <= wz_data;
      end
      if (wo_en) begin
        one_mem[cur] <= wo_data;
      end
      if (wr_en) begin
        route_mem[cur] <= wr_data;
      end
    end
    zero_q  <= zero_mem[rd_addr];
    one_q   <= one_mem[rd_addr];
    route_q <= route_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      next_free  <= FW'(1);
      root_zero  <= '0;
      root_one   <= '0;
      root_route <= '0;
      lvl        <= '0;
      fresh      <= 1'b0;
      cur        <= '0;
    end else if (cmd.load) begin
      cur   <= '0;
      lvl   <= '0;
      fresh <= 1'b0;
    end else if (cmd.step) begin
      if (at_root) begin
        if (wz_en) begin
          root_zero <= wz_data;
        end
        if (wo_en) begin
          root_one <= wo_data;
        end
        if (wr_en) begin
          root_route <= wr_data;
        end
      end
      if (advance) begin
        cur <= child;
        lvl <= lvl + LW'(1);
      end else if (alloc) begin
        cur       <= spare_node;
        lvl       <= lvl + LW'(1);
        fresh     <= 1'b1;
        next_free <= next_free + FW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      action  <= in_action;
      addr_sh <= in_address[ADDRESS_BITS-1:0];
      plen    <= (in_plen > PLEN_MAX) ? LVL_END : in_plen[LW-1:0];
      rid     <= in_rid;
      best    <= '0;
    end else if (cmd.step && (advance || alloc)) begin
      addr_sh <= addr_sh << 1;
      best    <= best_n;
    end
    if (cmd.out_load) begin
      out_found  <= res_found;
      out_route  <= res_route;
      out_status <= res_status;
    end
  end

  a_pool_bound: assert property (@(posedge clk) disable iff (rst)
    next_free != '0 && next_free <= POOL_END)
    else $error("node allocation counter out of range");

  a_fresh_not_root: assert property (@(posedge clk) disable iff (rst)
    fresh |-> (cur != '0 && action == ACT_INSERT))
    else $error("newly allocated node is the root or walk is a lookup");

  a_level_bound: assert property (@(posedge clk) disable iff (rst)
    lvl <= LVL_END)
    else $error("walk level beyond the address width");

  a_alloc_count: assert property (@(posedge clk) disable iff (rst)
    (cmd.step && alloc) |=> next_free == $past(next_free) + FW'(1))
    else $error("allocation did not advance the free node counter");

endmodule

`default_nettype wire

/* hw/rtl/btlpm_ctrl.sv */
// Controller of the trie block: accepts input beats, sequences the walk, owns m_tvalid.
// Drives btlpm_datapath through cmd_t and reads stat_t; depends on btlpm_pkg.
`default_nettype none

module btlpm_ctrl (
  input  wire               clk,
  input  wire               rst,
  input  wire               s_tvalid,
  output logic              s_tready,
  output logic              m_tvalid,
  input  wire               m_tready,
  input  btlpm_pkg::stat_t  stat,
  output btlpm_pkg::cmd_t   cmd
);
  import btlpm_pkg::*;

  typedef enum logic {
    ST_IDLE,
    ST_WALK
  } state_t;

  state_t state;
  logic   out_free;

  assign out_free     = !m_tvalid || m_tready;
  assign s_tready     = (state == ST_IDLE);
  assign cmd.load     = (state == ST_IDLE) && s_tvalid;
  assign cmd.step     = (state == ST_WALK) && (!stat.finish || out_free);
  assign cmd.out_load = (state == ST_WALK) && stat.finish && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            state <= ST_WALK;
          end
        end
        ST_WALK: begin
          if (cmd.out_load) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
      if (cmd.out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/binary_trie_longest_prefix_match.sv */
// Top level of the binary trie longest prefix match block.
// Instantiates btlpm_ctrl and btlpm_datapath; depends on btlpm_pkg.
//
// One input beat is either an insert (tuser low) or a lookup (tuser high).
// An insert walks the prefix one bit per cycle from the most significant
// address bit, allocates missing nodes from a bump counter and stores the
// route id at the last node. A lookup walks the address one level per cycle
// and returns the id of the deepest node on its path that holds a route.
// Every beat gives exactly one output beat; an aborted insert has tuser high.
// The walk visits one trie level at a time, set by the single read port of
// the node memory, and visits at most ADDRESS_BITS levels below the root;
// the result beat is presented after the last level is visited, and the
// next beat can be taken once the result has been loaded for output.
// Items are taken one at a time; a new beat is accepted while the previous
// result still waits in the output register. When the receiver stalls with a
// result pending, the next walk halts at its final step until it drains.
// Reset empties the trie at once: the root node lives in registers and is
// cleared, the free node counter returns to one, and the node memory needs
// no clearing pass because every node is cleared when it is allocated.
`default_nettype none

module binary_trie_longest_prefix_match #(
  parameter int NODE_COUNT   = 4096,
  parameter int ADDRESS_BITS = 32
) (
  input  wire                                  clk,
  input  wire                                  rst,
  input  wire                                  s_tvalid,
  output logic                                 s_tready,
  // address [31:0], prefix_length [37:32], route_id [53:38], zero pad [55:54]
  input  wire  [btlpm_pkg::IN_TDATA_W-1:0]     s_tdata,
  // action [0]
  input  wire                                  s_tuser,
  output logic                                 m_tvalid,
  input  wire                                  m_tready,
  // route_found [0], match_id [16:1], zero pad [23:17]
  output logic [btlpm_pkg::OUT_TDATA_W-1:0]    m_tdata,
  // status [0]
  output logic                                 m_tuser
);
  import btlpm_pkg::*;

  cmd_t             cmd;
  stat_t            stat;
  logic             out_found;
  logic [RID_W-1:0] out_route;

  btlpm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  btlpm_datapath #(
    .NODE_COUNT   (NODE_COUNT),
    .ADDRESS_BITS (ADDRESS_BITS)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .in_action  (s_tuser),
    .in_address (s_tdata[ADDR_W-1:0]),
    .in_plen    (s_tdata[ADDR_W+PLEN_W-1:ADDR_W]),
    .in_rid     (s_tdata[ADDR_W+PLEN_W+RID_W-1:ADDR_W+PLEN_W]),
    .out_found  (out_found),
    .out_route  (out_route),
    .out_status (m_tuser)
  );

  assign m_tdata = {{(OUT_TDATA_W-RID_W-1){1'b0}}, out_route, out_found};

endmodule

`default_nettype wire
